// File: hdl/cfu_pkg.sv
// cfu_pkg: shared constants for the cholesky factorization unit
// depends on nothing; imported by hdl/cholesky_factorization_unit.sv
package cfu_pkg;

  localparam int DEF_MAX_SIZE      = 8;
  localparam int DEF_FRACTION_BITS = 16;
  localparam int DATA_W            = 32;
  localparam int SIZE_W            = 4;
  localparam int IDX_W             = 3;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

endpackage

// File: hdl/cholesky_factorization_unit.sv
// cholesky_factorization_unit: sequenced lower cholesky factor, q-format fixed point
// depends on hdl/cfu_pkg.sv
//
// Usage: load the lower triangle of a symmetric matrix one element per input
// beat (row_index, col_index, element_value); elements above the diagonal are
// dropped. The beat with last_element set starts the factorization of the
// matrix_size x matrix_size matrix written through cfg_we/cfg_data.
// Input stall is low only in idle; while the factor is computed and streamed
// out the block stalls its input.
// A run handles one entry at a time: it reads, multiplies and accumulates each
// product term in turn, then takes a square root on the diagonal or a division
// off it (skipped when the diagonal is zero or negative), both done one bit a
// cycle by a shift-subtract datapath. Results then leave one beat at a time
// from the factor memory read port, lower triangle row by row.
// A negative pivot ends the run with a single beat carrying the error flag.
// When the receiver holds out_stall, the output register keeps its beat and
// the sequencer waits. Reset (rst, synchronous) returns to idle, sets
// matrix_size to 8; the element memories are not cleared.
module cholesky_factorization_unit
  import cfu_pkg::*;
#(
  parameter int MAX_SIZE      = DEF_MAX_SIZE,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [SIZE_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [IDX_W-1:0]         row_index,
  input  logic [IDX_W-1:0]         col_index,
  input  logic signed [DATA_W-1:0] element_value,
  input  logic                     last_element,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  output logic signed [DATA_W-1:0] factor_value,
  output logic                     not_positive_definite,
  output logic                     last_result
);

  localparam int DEPTH = MAX_SIZE * (MAX_SIZE + 1) / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam logic [63:0] SQRT_TOP = 64'h4000_0000_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_ENTRY, S_RD, S_MUL, S_ACC, S_IN_RD, S_REM, S_CHECK,
    S_SQRT, S_DIV, S_WRITE, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
  } state_t;

  state_t state;

  logic [SIZE_W-1:0]        matrix_size;
  logic [CW-1:0]            j, i, k, n_last;
  logic signed [63:0]       acc, prod;
  logic signed [DATA_W-1:0] rem, dval;
  logic [63:0]              sq_x, sq_res, sq_bit;
  logic [63:0]              dq;
  logic [DATA_W-1:0]        dr;
  logic [5:0]               cnt;
  logic                     neg;

  // element memories
  logic signed [DATA_W-1:0] in_mem  [DEPTH];
  logic signed [DATA_W-1:0] fac_mem [DEPTH];
  logic signed [DATA_W-1:0] rd_a, rd_b, rd_in;
  logic [AW-1:0]            addr_a, addr_b, addr_in, addr_ld;
  logic                     fac_we, in_we;
  logic signed [DATA_W-1:0] wval, qsat;

  function automatic logic [AW-1:0] tri_addr(input logic [3:0] r, input logic [3:0] c);
    logic [7:0] base;
    base = ({4'b0, r} * ({4'b0, r} + 8'd1)) >> 1;
    return AW'(base + {4'b0, c});
  endfunction

  // size clamp
  logic [SIZE_W-1:0] n_eff;
  always_comb begin
    n_eff = matrix_size;
    if (matrix_size == '0) n_eff = 4'd1;
    else if (32'(matrix_size) > MAX_SIZE) n_eff = SIZE_W'(MAX_SIZE);
  end

  // address selection
  assign addr_a  = (state == S_OUT_RD) ? tri_addr(4'(j), 4'(i)) : tri_addr(4'(j), 4'(k));
  assign addr_b  = (state == S_IN_RD) ? tri_addr(4'(i), 4'(i)) : tri_addr(4'(i), 4'(k));
  assign addr_in = tri_addr(4'(j), 4'(i));
  assign addr_ld = tri_addr(4'(row_index), 4'(col_index));
  assign in_we   = in_valid && !in_stall && (col_index <= row_index)
                   && (32'(row_index) < MAX_SIZE);
  assign fac_we  = (state == S_WRITE);

  // quotient saturation
  always_comb begin
    if (neg) qsat = (|dq[63:31]) ? 32'sh8000_0000 : -$signed(dq[31:0]);
    else     qsat = (|dq[63:31]) ? 32'sh7fff_ffff : $signed(dq[31:0]);
  end
  assign wval = (i == j) ? $signed(sq_res[31:0]) : qsat;

  // memory ports
  always_ff @(posedge clk) begin
    if (in_we) in_mem[addr_ld] <= element_value;
    if (fac_we) fac_mem[addr_in] <= wval;
    rd_a  <= fac_mem[addr_a];
    rd_b  <= fac_mem[addr_b];
    rd_in <= in_mem[addr_in];
  end

  // remainder with saturation
  logic signed [64:0] diff;
  logic signed [DATA_W-1:0] rem_sat;
  assign diff = 65'(rd_in) - 65'(acc);
  always_comb begin
    if (diff > 65'sh0_7fff_ffff) rem_sat = 32'sh7fff_ffff;
    else if (diff < -65'sh0_8000_0000) rem_sat = 32'sh8000_0000;
    else rem_sat = diff[31:0];
  end

  // shift-subtract step for square root and division
  logic [63:0] sq_try;
  logic [32:0] dv_try;
  logic        dv_ge;
  logic [32:0] mag;
  assign sq_try = sq_res + sq_bit;
  assign dv_try = {dr, dq[63]};
  assign dv_ge  = dv_try >= {1'b0, dval};
  assign mag    = rem[31] ? (33'd0 - 33'(rem)) : {1'b0, rem};

  assign in_stall = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      matrix_size <= SIZE_RESET;
      out_valid   <= 1'b0;
      j <= '0; i <= '0; k <= '0;
    end else begin
      if (cfg_we) matrix_size <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (in_valid && last_element) begin
            n_last <= CW'(n_eff - 4'd1);
            j <= '0;
            i <= '0;
            state <= S_ENTRY;
          end
        end
        S_ENTRY: begin
          acc <= '0;
          k <= '0;
          state <= S_RD;
        end
        S_RD: state <= (k == i) ? S_IN_RD : S_MUL;
        S_MUL: begin
          prod <= rd_a * rd_b;
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc + (prod >>> FRACTION_BITS);
          k <= k + 1'b1;
          state <= S_RD;
        end
        S_IN_RD: state <= S_REM;
        S_REM: begin
          rem <= rem_sat;
          dval <= rd_b;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (i == j) begin
            if (rem[31]) begin
              out_row <= IDX_W'(j);
              out_col <= IDX_W'(j);
              factor_value <= '0;
              not_positive_definite <= 1'b1;
              last_result <= 1'b1;
              out_valid <= 1'b1;
              state <= S_OUT_WAIT;
            end else begin
              sq_x <= {32'b0, rem} << FRACTION_BITS;
              sq_res <= '0;
              sq_bit <= SQRT_TOP;
              state <= S_SQRT;
            end
          end else begin
            neg <= rem[31];
            dr <= '0;
            cnt <= '0;
            if (dval[31] || dval == '0) begin
              dq <= '0;
              state <= S_WRITE;
            end else begin
              dq <= 64'(mag) << FRACTION_BITS;
              state <= S_DIV;
            end
          end
        end
        S_SQRT: begin
          if (sq_x >= sq_try) begin
            sq_x <= sq_x - sq_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit == 64'd1) state <= S_WRITE;
        end
        S_DIV: begin
          dr <= dv_ge ? DATA_W'(dv_try - {1'b0, dval}) : dv_try[31:0];
          dq <= {dq[62:0], dv_ge};
          cnt <= cnt + 1'b1;
          if (cnt == 6'd63) state <= S_WRITE;
        end
        S_WRITE: begin
          if (i == j) begin
            i <= '0;
            if (j == n_last) begin
              j <= '0;
              state <= S_OUT_RD;
            end else begin
              j <= j + 1'b1;
              state <= S_ENTRY;
            end
          end else begin
            i <= i + 1'b1;
            state <= S_ENTRY;
          end
        end
        S_OUT_RD: state <= S_OUT_LD;
        S_OUT_LD: begin
          out_row <= IDX_W'(j);
          out_col <= IDX_W'(i);
          factor_value <= rd_a;
          not_positive_definite <= 1'b0;
          last_result <= (j == n_last) && (i == j);
          out_valid <= 1'b1;
          state <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_result) begin
              state <= S_IDLE;
            end else begin
              if (i == j) begin
                i <= '0;
                j <= j + 1'b1;
              end else begin
                i <= i + 1'b1;
              end
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
